[sv/fixed_frame_deframer_crc8_assert.svh]
// Assertion macros for the deframer. Each macro checks one implication on the
// rising clock edge and is disabled while reset is high.
`ifndef FIXED_FRAME_DEFRAMER_CRC8_ASSERT_SVH
`define FIXED_FRAME_DEFRAMER_CRC8_ASSERT_SVH

// Same-cycle implication.
`define FFDC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication.
`define FFDC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

[sv/ffdc_pkg.sv]
package ffdc_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_TAIL  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CTRL  = 2'd2;
   localparam logic [1:0] STATUS_BAD_CRC   = 2'd3;

   // Input word kinds.
   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // Configuration register indexes.
   localparam int CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] CSR_HEADER_FIRST  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_HEADER_SECOND = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_TAIL_VALUE    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_CTRL_LOWEST   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_CTRL_HIGHEST  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_SLOT_COMMANDS = 3'd5;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [2:0] NO_SLOT  = 3'd4;
   localparam int MaxSlots = 4;

   typedef logic [7:0] byte_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic byte_type crc8_fold(byte_type crc, byte_type b);
      byte_type v;
      v = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

[sv/fixed_frame_deframer_crc8.sv]
// Fixed-length frame deframer with CRC-8 check.
// The req channel carries one received link byte per word in req_tdata; req_tuser
// set to one marks a flush that drops synchronization instead of a data byte.
// The block hunts for the two header bytes, collects the control byte, the
// payload, the CRC byte, the ignored counter byte and the tail byte, and checks
// the frame when the tail arrives. A good frame yields PAYLOAD_LEN rsp words, a
// bad frame yields one error word; rsp_tlast marks the final word of each run.
// Every input word is absorbed at once, so req_tready is normally high and a byte
// can be taken on every clock outside the stall below. The first result word of
// a frame is valid in the cycle after the tail byte is accepted; the run leaves
// at one word per cycle while rsp_tready is high, from a separate result buffer,
// so the next frame is collected while the run drains. The result buffer sets the
// only stall: the word in the tail position is held off (req_tready low) while an
// earlier run is pending, through the cycle in which its final word is taken.
// Synchronous reset restores the register defaults, clears synchronization and
// drops any pending run. The csr port writes one register per cycle by index
// and should only be used while the block is idle.
module fixed_frame_deframer_crc8 #(
   parameter int PAYLOAD_LEN = 10,
   parameter int SLOT_COUNT  = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input words.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   input  logic                            req_tuser,  // [0] cmd
   // Result words.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] ctrl_value, [10:8] slot_index, [14:11] byte_index,
   // [22:15] payload_byte, [23] zero
   output logic [23:0]                     rsp_tdata,
   output logic [1:0]                      rsp_tuser,  // [1:0] status
   output logic                            rsp_tlast,
   // Configuration writes.
   input  logic                            csr_we,
   input  logic [ffdc_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [31:0]                     csr_wdata
);
   import ffdc_pkg::*;

   // Position counter covers header, control, payload, CRC, counter and tail.
   localparam int PosW = $clog2(PAYLOAD_LEN + 6);
   localparam int IdxW = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
   localparam logic [PosW-1:0] PosCtrl = PosW'(2);
   localparam logic [PosW-1:0] PosCrc  = PosW'(3 + PAYLOAD_LEN);
   localparam logic [PosW-1:0] PosTail = PosW'(5 + PAYLOAD_LEN);
   localparam logic [IdxW-1:0] IdxLast = IdxW'(PAYLOAD_LEN - 1);

   // Configuration registers.
   logic [7:0]  hdr_first_ff, hdr_second_ff, tail_val_ff, ctrl_lo_ff, ctrl_hi_ff;
   logic [31:0] slot_cmds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= 8'h55;
         hdr_second_ff <= 8'hAA;
         tail_val_ff   <= 8'h00;
         ctrl_lo_ff    <= 8'h09;
         ctrl_hi_ff    <= 8'h0C;
         slot_cmds_ff  <= 32'h0C0B0A09;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_FIRST: begin
               hdr_first_ff <= csr_wdata[7:0];
            end
            CSR_HEADER_SECOND: begin
               hdr_second_ff <= csr_wdata[7:0];
            end
            CSR_TAIL_VALUE: begin
               tail_val_ff <= csr_wdata[7:0];
            end
            CSR_CTRL_LOWEST: begin
               ctrl_lo_ff <= csr_wdata[7:0];
            end
            CSR_CTRL_HIGHEST: begin
               ctrl_hi_ff <= csr_wdata[7:0];
            end
            CSR_SLOT_COMMANDS: begin
               slot_cmds_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Synchronization state.
   logic [PosW-1:0] pos_ff, pos_in;
   logic            inside_ff, inside_in;
   logic [7:0]      crc_ff, crc_in;
   logic [7:0]      held_ctrl_ff, held_crc_ff;
   logic [7:0]      pay_store_ff [PAYLOAD_LEN];

   // Result run state.
   logic            run_active_ff, run_active_in;
   logic            run_error_ff;
   logic [IdxW-1:0] run_idx_ff, run_idx_in;
   logic [1:0]      run_status_ff;
   logic [7:0]      run_ctrl_ff;
   logic [2:0]      run_slot_ff;
   logic [7:0]      run_buf_ff [PAYLOAD_LEN];

   logic            req_acc, rsp_acc;
   logic            at_tail, frame_end;
   logic [7:0]      rx;
   logic [1:0]      end_status;
   logic [2:0]      slot_match;
   logic [PosW-1:0] store_pos;
   logic [IdxW-1:0] store_idx;

   assign rx = req_tdata;
   assign at_tail = inside_ff && (pos_ff == PosTail);

   // Only a tail byte can start a run, so only the word in the tail position
   // is held off while the result buffer is still busy.
   assign req_tready = !(run_active_ff && at_tail);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign frame_end  = req_acc && (req_tuser == CMD_DATA) && at_tail;

   assign store_pos = pos_ff - PosW'(3);
   assign store_idx = store_pos[IdxW-1:0];

   // Checks in priority order: tail, control range, then CRC unless the field
   // is zero.
   always_comb begin
      if (rx != tail_val_ff) begin
         end_status = STATUS_BAD_TAIL;
      end else if (held_ctrl_ff < ctrl_lo_ff || held_ctrl_ff > ctrl_hi_ff) begin
         end_status = STATUS_BAD_CTRL;
      end else if (held_crc_ff != 8'h00 && held_crc_ff != crc_ff) begin
         end_status = STATUS_BAD_CRC;
      end else begin
         end_status = STATUS_OK;
      end
   end

   // Lowest matching slot wins.
   always_comb begin
      slot_match = NO_SLOT;
      for (int i = MaxSlots - 1; i >= 0; i--) begin
         if (i < SLOT_COUNT && slot_cmds_ff[8*i +: 8] == held_ctrl_ff) begin
            slot_match = 3'(i);
         end
      end
   end

   // Header hunt and frame collection.
   always_comb begin
      pos_in    = pos_ff;
      inside_in = inside_ff;
      crc_in    = crc_ff;
      if (req_acc) begin
         if (req_tuser == CMD_FLUSH) begin
            pos_in    = '0;
            inside_in = 1'b0;
            crc_in    = 8'h00;
         end else if (!inside_ff) begin
            if (pos_ff == PosW'(0) && rx == hdr_first_ff) begin
               crc_in = crc8_fold(8'h00, rx);
               pos_in = PosW'(1);
            end else if (pos_ff == PosW'(1) && rx == hdr_second_ff) begin
               crc_in    = crc8_fold(crc_ff, rx);
               pos_in    = PosW'(2);
               inside_in = 1'b1;
            end else if (rx == hdr_first_ff) begin
               // A stray first header byte restarts the hunt at once.
               crc_in = crc8_fold(8'h00, rx);
               pos_in = PosW'(1);
            end else begin
               pos_in = '0;
               crc_in = 8'h00;
            end
         end else if (pos_ff >= PosTail) begin
            pos_in    = '0;
            inside_in = 1'b0;
            crc_in    = 8'h00;
         end else begin
            if (pos_ff < PosCrc) begin
               crc_in = crc8_fold(crc_ff, rx);
            end
            pos_in = pos_ff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         inside_ff <= 1'b0;
         crc_ff    <= 8'h00;
      end else begin
         pos_ff    <= pos_in;
         inside_ff <= inside_in;
         crc_ff    <= crc_in;
      end
   end

   // Frame field capture; these hold no reset value.
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == CMD_DATA && inside_ff) begin
         if (pos_ff == PosCtrl) begin
            held_ctrl_ff <= rx;
         end else if (pos_ff > PosCtrl && pos_ff < PosCrc) begin
            pay_store_ff[store_idx] <= rx;
         end else if (pos_ff == PosCrc) begin
            held_crc_ff <= rx;
         end
      end
   end

   // The whole payload moves to the result buffer at frame end.
   always_ff @(posedge clock) begin
      if (frame_end) begin
         run_error_ff  <= (end_status != STATUS_OK);
         run_status_ff <= end_status;
         run_ctrl_ff   <= held_ctrl_ff;
         run_slot_ff   <= (end_status != STATUS_OK) ? NO_SLOT : slot_match;
         for (int k = 0; k < PAYLOAD_LEN; k++) begin
            run_buf_ff[k] <= pay_store_ff[k];
         end
      end
   end

   // Run sequencing.
   always_comb begin
      run_active_in = run_active_ff;
      run_idx_in    = run_idx_ff;
      if (frame_end) begin
         run_active_in = 1'b1;
         run_idx_in    = '0;
      end else if (rsp_acc) begin
         if (rsp_tlast) begin
            run_active_in = 1'b0;
         end else begin
            run_idx_in = run_idx_ff + IdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         run_idx_ff    <= '0;
      end else begin
         run_active_ff <= run_active_in;
         run_idx_ff    <= run_idx_in;
      end
   end

   // Result word assembly. An error word carries index and payload zero.
   logic [31:0] idx_wide;
   logic [3:0]  out_bidx;
   logic [7:0]  out_payload;

   assign idx_wide    = 32'(run_idx_ff);
   assign out_bidx    = run_error_ff ? 4'd0 : idx_wide[3:0];
   assign out_payload = run_error_ff ? 8'h00 : run_buf_ff[run_idx_ff];

   assign rsp_tvalid = run_active_ff;
   assign rsp_tlast  = run_error_ff || (run_idx_ff == IdxLast);
   assign rsp_tuser  = run_status_ff;
   assign rsp_tdata  = {1'b0, out_payload, out_bidx, run_slot_ff, run_ctrl_ff};

`include "fixed_frame_deframer_crc8_assert.svh"

   `FFDC_ASSERT_NOW(a_err_single, rsp_tvalid && rsp_tuser != STATUS_OK, rsp_tlast)
   `FFDC_ASSERT_NEXT(a_run_ends, rsp_acc && rsp_tlast && !frame_end, !rsp_tvalid)
   `FFDC_ASSERT_NEXT(a_flush_drops, req_acc && req_tuser == CMD_FLUSH, !inside_ff && pos_ff == '0)
   `FFDC_ASSERT_NOW(a_inside_pos, inside_ff, pos_ff >= PosCtrl)

endmodule
